### hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define CBCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define CBCR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/cbcr_pkg.sv
// Package with types, constants and helper functions of the collision response unit.
package cbcr_pkg;

  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 32;
  localparam int LINE_LEN    = SQRT_STAGES + 1 + DIV_STAGES;

  localparam logic [2:0] REG_LEFT   = 3'd0;
  localparam logic [2:0] REG_TOP    = 3'd1;
  localparam logic [2:0] REG_RIGHT  = 3'd2;
  localparam logic [2:0] REG_BOTTOM = 3'd3;
  localparam logic [2:0] REG_RADIUS = 3'd4;
  localparam logic [2:0] REG_SLIDE  = 3'd5;

  localparam logic [30:0] SLIDE_RESET = 31'd196608;
  localparam logic [63:0] ROUND_HALF  = 64'h0000_0000_0000_8000;

  typedef enum logic [2:0] {
    SIDE_NONE   = 3'd0,
    SIDE_TOP    = 3'd1,
    SIDE_BOTTOM = 3'd2,
    SIDE_LEFT   = 3'd3,
    SIDE_RIGHT  = 3'd4
  } side_t;

  typedef struct packed {
    logic               hit;
    side_t              side;
    logic               jump;
    logic               zero;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               sx;
    logic               sy;
    logic [30:0]        mdx;
    logic [30:0]        mdy;
  } band_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

### hw/rtl/circle_box_collision_response_unit.sv
// Top level of the circle versus box collision response unit.
// Usage: a circle word (pos_x, pos_y, force_x, force_y) enters on the in_ channel and
// is tested against the box and radius held in the configuration registers.
// Each accepted word yields exactly one result word on the out_ channel, in order.
// Registers are written through cfg_we, cfg_index and cfg_data. The user must write
// them only while the unit is idle; the unit itself does not enforce it. The pipeline
// has three front stages (clamp, squares, hit decision), 32 square root stages, one
// numerator multiply, 32 divider stages and the output register.
// Throughput is one word per cycle while not stalled; every stage advances together.
// When the receiver stalls with a word waiting, the whole pipeline holds and in_stall
// rises in the same cycle, so nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults: a zero box, zero radius
// and a slide gain of three.
module circle_box_collision_response_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_force_x,
  input  logic signed [31:0] in_force_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic [2:0]         out_contact_side,
  output logic signed [31:0] out_new_pos_x,
  output logic signed [31:0] out_new_pos_y,
  output logic signed [31:0] out_new_force_x,
  output logic signed [31:0] out_new_force_y,
  output logic               out_can_jump
);
  import cbcr_pkg::*;

  logic               en;
  logic signed [31:0] left_r, top_r, right_r, bottom_r;
  logic [30:0]        radius_r, slide_r;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      right_r  <= '0;
      bottom_r <= '0;
      radius_r <= '0;
      slide_r  <= SLIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT:   left_r   <= cfg_data;
        REG_TOP:    top_r    <= cfg_data;
        REG_RIGHT:  right_r  <= cfg_data;
        REG_BOTTOM: bottom_r <= cfg_data;
        REG_RADIUS: radius_r <= cfg_data[30:0];
        REG_SLIDE:  slide_r  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Stage 1: closest point and offsets.
  logic               v1_r;
  logic signed [31:0] px1_r, py1_r, fx1_r, fy1_r, cx1_r, cy1_r;
  logic signed [32:0] dx1_r, dy1_r, sld1_r;
  logic               top1_r, bot1_r, lft1_r, rgt1_r, son1_r;
  logic signed [31:0] cx_c, cy_c;

  always_comb begin
    cx_c = (in_pos_x < left_r) ? left_r : in_pos_x;
    if (cx_c > right_r) begin
      cx_c = right_r;
    end
    cy_c = (in_pos_y < bottom_r) ? bottom_r : in_pos_y;
    if (cy_c > top_r) begin
      cy_c = top_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r  <= in_pos_x;
      py1_r  <= in_pos_y;
      fx1_r  <= in_force_x;
      fy1_r  <= in_force_y;
      cx1_r  <= cx_c;
      cy1_r  <= cy_c;
      dx1_r  <= 33'(in_pos_x) - 33'(cx_c);
      dy1_r  <= 33'(in_pos_y) - 33'(cy_c);
      sld1_r <= (in_pos_x > right_r) ? 33'(in_pos_x) - 33'(right_r)
                                     : 33'(in_pos_x) - 33'(left_r);
      top1_r <= cy_c == top_r;
      bot1_r <= cy_c == bottom_r;
      lft1_r <= cx_c == left_r;
      rgt1_r <= cx_c == right_r;
      son1_r <= (in_pos_x > right_r) || (in_pos_x < left_r);
    end
  end

  // Stage 2: magnitudes and products.
  logic               v2_r;
  logic signed [31:0] px2_r, py2_r, fx2_r, fy2_r, cx2_r, cy2_r;
  logic               top2_r, bot2_r, lft2_r, rgt2_r, son2_r, pre2_r;
  logic               sx2_r, sy2_r, ss2_r;
  logic [30:0]        mdx2_r, mdy2_r;
  logic [61:0]        sqx2_r, sqy2_r, rr2_r;
  logic [63:0]        sp2_r;
  logic [32:0]        mdx_c, mdy_c, msl_c;

  always_comb begin
    mdx_c = dx1_r[32] ? 33'(-dx1_r) : 33'(dx1_r);
    mdy_c = dy1_r[32] ? 33'(-dy1_r) : 33'(dy1_r);
    msl_c = sld1_r[32] ? 33'(-sld1_r) : 33'(sld1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px2_r  <= px1_r;
      py2_r  <= py1_r;
      fx2_r  <= fx1_r;
      fy2_r  <= fy1_r;
      cx2_r  <= cx1_r;
      cy2_r  <= cy1_r;
      top2_r <= top1_r;
      bot2_r <= bot1_r;
      lft2_r <= lft1_r;
      rgt2_r <= rgt1_r;
      son2_r <= son1_r;
      pre2_r <= (mdx_c < {2'b00, radius_r}) && (mdy_c < {2'b00, radius_r});
      sx2_r  <= dx1_r[32];
      sy2_r  <= dy1_r[32];
      ss2_r  <= sld1_r[32];
      mdx2_r <= mdx_c[30:0];
      mdy2_r <= mdy_c[30:0];
      sqx2_r <= mdx_c[30:0] * mdx_c[30:0];
      sqy2_r <= mdy_c[30:0] * mdy_c[30:0];
      rr2_r  <= radius_r * radius_r;
      sp2_r  <= 64'(slide_r) * 64'(msl_c);
    end
  end

  // Stage 3: hit decision, contact side and forces.
  logic        v3_r;
  band_t       band3_r;
  logic [62:0] d2_3_r;
  band_t       band_c;
  logic [62:0] d2_c;
  logic [47:0] sterm_c;
  logic signed [63:0] sadd_c;

  always_comb begin
    d2_c    = 63'(sqx2_r) + 63'(sqy2_r);
    sterm_c = 48'((sp2_r + ROUND_HALF) >> 16);
    sadd_c  = ss2_r ? -64'(sterm_c) : 64'(sterm_c);
    band_c      = '0;
    band_c.hit  = pre2_r && (d2_c < {1'b0, rr2_r});
    band_c.side = SIDE_NONE;
    band_c.jump = 1'b0;
    band_c.zero = d2_c == 63'd0;
    band_c.px   = px2_r;
    band_c.py   = py2_r;
    band_c.fx   = fx2_r;
    band_c.fy   = fy2_r;
    band_c.cx   = cx2_r;
    band_c.cy   = cy2_r;
    band_c.sx   = sx2_r;
    band_c.sy   = sy2_r;
    band_c.mdx  = mdx2_r;
    band_c.mdy  = mdy2_r;
    if (band_c.hit) begin
      priority if (top2_r) begin
        band_c.side = SIDE_TOP;
        band_c.jump = 1'b1;
        if (fy2_r < 0) begin
          band_c.fy = '0;
        end
        if (son2_r) begin
          band_c.fx = sat32(64'(fx2_r) + sadd_c);
        end
      end else if (bot2_r) begin
        band_c.side = SIDE_BOTTOM;
        if (fy2_r > 0) begin
          band_c.fy = '0;
        end
      end else if (lft2_r) begin
        band_c.side = SIDE_LEFT;
        if (fx2_r < 0) begin
          band_c.fx = '0;
        end
      end else if (rgt2_r) begin
        band_c.side = SIDE_RIGHT;
        if (fx2_r > 0) begin
          band_c.fx = '0;
        end
      end else begin
        band_c.side = SIDE_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      band3_r <= band_c;
      d2_3_r  <= d2_c;
    end
  end

  // Side band that travels beside the root and divider stages.
  band_t         line_r [LINE_LEN];
  logic [LINE_LEN-1:0] vl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r <= '0;
    end else if (en) begin
      vl_r <= {vl_r[LINE_LEN-2:0], v3_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      line_r[0] <= band3_r;
      for (int i = 1; i < LINE_LEN; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end
  end

  logic [30:0] len;

  cbcr_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .d2   (d2_3_r),
    .root (len)
  );

  // Numerator stage: radius times offset plus half the length.
  logic [62:0] numx_r, numy_r;
  logic [30:0] len_r;
  band_t       bs_c;

  assign bs_c = line_r[SQRT_STAGES-1];

  always_ff @(posedge clk) begin
    if (en) begin
      numx_r <= 63'(radius_r) * 63'(bs_c.mdx) + 63'(len >> 1);
      numy_r <= 63'(radius_r) * 63'(bs_c.mdy) + 63'(len >> 1);
      len_r  <= len;
    end
  end

  logic [31:0] qx, qy;

  cbcr_div u_divx (
    .clk (clk),
    .en  (en),
    .num (numx_r),
    .den (len_r),
    .quo (qx)
  );

  cbcr_div u_divy (
    .clk (clk),
    .en  (en),
    .num (numy_r),
    .den (len_r),
    .quo (qy)
  );

  // Output stage: push out along the offset and saturate.
  band_t              bf_c;
  logic signed [63:0] offx_c, offy_c;
  logic signed [31:0] nx_c, ny_c;
  logic               out_valid_r, out_hit_r, out_can_jump_r;
  logic [2:0]         out_side_r;
  logic signed [31:0] out_px_r, out_py_r, out_fx_r, out_fy_r;

  always_comb begin
    bf_c   = line_r[LINE_LEN-1];
    offx_c = bf_c.sx ? -64'(qx) : 64'(qx);
    offy_c = bf_c.sy ? -64'(qy) : 64'(qy);
    if (bf_c.hit && !bf_c.zero) begin
      nx_c = sat32(64'(bf_c.cx) + offx_c);
      ny_c = sat32(64'(bf_c.cy) + offy_c);
    end else begin
      nx_c = bf_c.px;
      ny_c = bf_c.py;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vl_r[LINE_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r      <= bf_c.hit;
      out_side_r     <= bf_c.side;
      out_can_jump_r <= bf_c.jump;
      out_px_r       <= nx_c;
      out_py_r       <= ny_c;
      out_fx_r       <= bf_c.fx;
      out_fy_r       <= bf_c.fy;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_contact_side = out_side_r;
  assign out_can_jump     = out_can_jump_r;
  assign out_new_pos_x    = out_px_r;
  assign out_new_pos_y    = out_py_r;
  assign out_new_force_x  = out_fx_r;
  assign out_new_force_y  = out_fy_r;

`include "assert_macros.svh"

  `CBCR_ASSERT_ALWAYS(a_stall_follows_output, in_stall == (out_valid && out_stall), "input stall does not match held output")
  `CBCR_ASSERT(a_jump_only_on_top, out_valid && out_can_jump |-> out_contact_side == SIDE_TOP, "can_jump without top contact")
  `CBCR_ASSERT(a_miss_is_clean, out_valid && !out_hit |-> out_contact_side == SIDE_NONE && !out_can_jump, "contact reported without a hit")
  `CBCR_ASSERT(a_valid_cleared, $past(!rst_n) |-> !out_valid, "output valid after reset")

endmodule

### hw/rtl/cbcr_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module cbcr_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [62:0] d2,
  output logic [30:0] root
);
  import cbcr_pkg::*;

  logic [62:0] n_r   [SQRT_STAGES];
  logic [63:0] res_r [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [62:0] n_in;
    logic [63:0] res_in;
    logic [63:0] trial;
    logic [62:0] n_nxt;
    logic [63:0] res_nxt;

    always_comb begin
      if (k == 0) begin
        n_in   = d2;
        res_in = 64'd0;
      end else begin
        n_in   = n_r[(k == 0) ? 0 : k - 1];
        res_in = res_r[(k == 0) ? 0 : k - 1];
      end
      trial = res_in + BIT;
      if ({1'b0, n_in} >= trial) begin
        n_nxt   = 63'({1'b0, n_in} - trial);
        res_nxt = (res_in >> 1) + BIT;
      end else begin
        n_nxt   = n_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]   <= n_nxt;
        res_r[k] <= res_nxt;
      end
    end
  end

  assign root = res_r[SQRT_STAGES-1][30:0];

endmodule

### hw/rtl/cbcr_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module cbcr_div (
  input  logic        clk,
  input  logic        en,
  input  logic [62:0] num,
  input  logic [30:0] den,
  output logic [31:0] quo
);
  import cbcr_pkg::*;

  logic [30:0] rem_r [DIV_STAGES];
  logic [31:0] lo_r  [DIV_STAGES];
  logic [31:0] q_r   [DIV_STAGES];
  logic [30:0] den_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [30:0] rem_in;
    logic [31:0] lo_in;
    logic [31:0] q_in;
    logic [30:0] den_in;
    logic [31:0] t;
    logic        ge;
    logic [30:0] rem_nxt;

    always_comb begin
      if (k == 0) begin
        rem_in = num[62:32];
        lo_in  = num[31:0];
        q_in   = 32'd0;
        den_in = den;
      end else begin
        rem_in = rem_r[(k == 0) ? 0 : k - 1];
        lo_in  = lo_r[(k == 0) ? 0 : k - 1];
        q_in   = q_r[(k == 0) ? 0 : k - 1];
        den_in = den_r[(k == 0) ? 0 : k - 1];
      end
      t  = {rem_in, lo_in[31]};
      ge = t >= {1'b0, den_in};
      if (ge) begin
        rem_nxt = 31'(t - {1'b0, den_in});
      end else begin
        rem_nxt = t[30:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        lo_r[k]  <= {lo_in[30:0], 1'b0};
        q_r[k]   <= {q_in[30:0], ge};
        den_r[k] <= den_in;
      end
    end
  end

  assign quo = q_r[DIV_STAGES-1];

endmodule

### test/cbcr_checker.sv
// Checker that predicts each collision result and compares it with the unit's output.
`timescale 1ns / 1ps
module cbcr_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_force_x,
  input  logic signed [31:0] in_force_y,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_hit,
  input  logic [2:0]         out_contact_side,
  input  logic signed [31:0] out_new_pos_x,
  input  logic signed [31:0] out_new_pos_y,
  input  logic signed [31:0] out_new_force_x,
  input  logic signed [31:0] out_new_force_y,
  input  logic               out_can_jump,
  output int                 errors,
  output int                 pending
);
  import cbcr_pkg::*;

  typedef struct {
    logic        hit;
    side_t       side;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] fx;
    logic [31:0] fy;
    logic        jump;
  } response_t;

  longint box_l, box_t, box_r, box_b;
  longint unsigned radius, slide;
  response_t expected_q[$];

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint push_out(longint d, longint unsigned len);
    longint unsigned q;
    q = (radius * magnitude(d) + len / 2) / len;
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint slide_push(longint d);
    longint unsigned p;
    p = (slide * magnitude(d) + 64'h8000) >> 16;
    return d < 0 ? -longint'(p) : longint'(p);
  endfunction

  function automatic response_t resolve(longint px, longint py, longint fx, longint fy);
    response_t r;
    longint cx, cy, dx, dy, nx, ny;
    longint unsigned d2, len;
    nx = px;
    ny = py;
    r.hit = 0;
    r.side = SIDE_NONE;
    r.jump = 0;
    cx = px < box_l ? box_l : px;
    if (cx > box_r) cx = box_r;
    cy = py < box_b ? box_b : py;
    if (cy > box_t) cy = box_t;
    dx = px - cx;
    dy = py - cy;
    if (magnitude(dx) < radius && magnitude(dy) < radius) begin
      d2 = magnitude(dx) * magnitude(dx) + magnitude(dy) * magnitude(dy);
      if (d2 < radius * radius) begin
        r.hit = 1;
        if (cy == box_t) begin
          r.side = SIDE_TOP;
          r.jump = 1;
          if (fy < 0) fy = 0;
          if (px > box_r) fx = clip32(fx + slide_push(px - box_r));
          else if (px < box_l) fx = clip32(fx + slide_push(px - box_l));
        end else if (cy == box_b) begin
          r.side = SIDE_BOTTOM;
          if (fy > 0) fy = 0;
        end else if (cx == box_l) begin
          r.side = SIDE_LEFT;
          if (fx < 0) fx = 0;
        end else if (cx == box_r) begin
          r.side = SIDE_RIGHT;
          if (fx > 0) fx = 0;
        end
        if (d2 != 0) begin
          len = int_sqrt(d2);
          nx = clip32(cx + push_out(dx, len));
          ny = clip32(cy + push_out(dy, len));
        end
      end
    end
    r.px = nx[31:0];
    r.py = ny[31:0];
    r.fx = fx[31:0];
    r.fy = fy[31:0];
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    response_t e;
    if (!rst_n) begin
      box_l <= 0;
      box_t <= 0;
      box_r <= 0;
      box_b <= 0;
      radius <= 0;
      slide <= SLIDE_RESET;
      errors <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEFT: box_l <= longint'($signed(cfg_data));
          REG_TOP: box_t <= longint'($signed(cfg_data));
          REG_RIGHT: box_r <= longint'($signed(cfg_data));
          REG_BOTTOM: box_b <= longint'($signed(cfg_data));
          REG_RADIUS: radius <= cfg_data[30:0];
          REG_SLIDE: slide <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_q.push_back(resolve(in_pos_x, in_pos_y, in_force_x, in_force_y));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result word with no prediction waiting");
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_hit !== e.hit || out_contact_side !== e.side || out_can_jump !== e.jump ||
              out_new_pos_x !== e.px || out_new_pos_y !== e.py ||
              out_new_force_x !== e.fx || out_new_force_y !== e.fy) begin
            errors <= errors + 1;
            if (out_hit !== e.hit) $error("hit: expected %0d, got %0d", e.hit, out_hit);
            if (out_contact_side !== e.side)
              $error("contact_side: expected %0d, got %0d", e.side, out_contact_side);
            if (out_can_jump !== e.jump)
              $error("can_jump: expected %0d, got %0d", e.jump, out_can_jump);
            if (out_new_pos_x !== e.px)
              $error("new_pos_x: expected %h, got %h", e.px, out_new_pos_x);
            if (out_new_pos_y !== e.py)
              $error("new_pos_y: expected %h, got %h", e.py, out_new_pos_y);
            if (out_new_force_x !== e.fx)
              $error("new_force_x: expected %h, got %h", e.fx, out_new_force_x);
            if (out_new_force_y !== e.fy)
              $error("new_force_y: expected %h, got %h", e.fy, out_new_force_y);
          end
        end
      end
    end
  end

endmodule

### test/tb_circle_box_collision_response_unit.sv
// Testbench top that drives box settings and circle words into the collision unit.
`timescale 1ns / 1ps
module tb_circle_box_collision_response_unit;
  import cbcr_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = REG_LEFT;
  logic [31:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] in_pos_x = 0, in_pos_y = 0, in_force_x = 0, in_force_y = 0;
  logic out_valid;
  logic out_stall = 0;
  logic out_hit, out_can_jump;
  logic [2:0] out_contact_side;
  logic signed [31:0] out_new_pos_x, out_new_pos_y, out_new_force_x, out_new_force_y;
  int errors, pending;
  int idle_pct = 38;
  bit hold_off = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  circle_box_collision_response_unit DUT (.*);
  cbcr_checker u_checker (.*);

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  always @(negedge clk) begin
    if (hold_off) out_stall <= 1;
    else out_stall <= ($urandom_range(99) < idle_pct);
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic set_box(input int l, input int t, input int r, input int b,
                         input int rad, input int gain);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    write_reg(REG_LEFT, l);
    write_reg(REG_TOP, t);
    write_reg(REG_RIGHT, r);
    write_reg(REG_BOTTOM, b);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_SLIDE, gain);
    cfg_we <= 0;
  endtask

  task automatic send_circle(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] fx, input logic [31:0] fy);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_pos_x <= px;
    in_pos_y <= py;
    in_force_x <= fx;
    in_force_y <= fy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic int near(int base, int span);
    return base + $signed($urandom_range(2 * span)) - span;
  endfunction

  initial begin
    int l, t, r, b, rad;
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    send_circle(0, 0, 5, -5);
    set_box(-32'sh40000, 32'sh20000, 32'sh40000, -32'sh20000, 32'h10000, 32'h30000);
    send_circle(0, 32'h28000, 32'h1000, -32'h1000);
    send_circle(32'h48000, 32'h28000, 32'h1000, -32'h1000);
    send_circle(-32'h48000, 32'h28000, 32'h1000, -32'h1000);
    send_circle(0, -32'h28000, 32'h1000, 32'h1000);
    send_circle(-32'h48000, 0, -32'h1000, 5);
    send_circle(32'h48000, 0, 32'h1000, 5);
    send_circle(0, 0, 32'h7FFFFFFF, 32'h80000000);
    send_circle(0, 32'h20000, 7, -7);
    send_circle(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
    send_circle(0, 32'h28000, 32'h1000, -32'h1000);
    set_box(32'h7FFF0000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFF0000, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_circle(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    send_circle(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    send_circle(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
    set_box(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h40000, 0);
    send_circle(5, 5, 1, 1);
    send_circle(32'h7FFF8000, 32'h80000000, -1, -1);
    set_box(32'h40000, 32'h10000, -32'h40000, 32'h20000, 32'h40000, 32'h7FFFFFFF);
    send_circle(0, 32'h18000, 32'h7FFFFFF0, -1);
    send_circle(-32'h50000, 32'h30000, 32'h80000010, -1);
    send_circle(32'h70000, 32'h30000, 32'h7FFFFFF0, -1);
    for (int ph = 0; ph < 10; ph++) begin
      l = $signed($urandom_range(32'h80000)) - 32'h40000;
      b = $signed($urandom_range(32'h80000)) - 32'h40000;
      r = l + $urandom_range(32'h80000);
      t = b + $urandom_range(32'h80000);
      rad = (ph == 3) ? 0 : $urandom_range(32'h60000, 1);
      if (ph == 8) begin
        r = l - 32'h10000;
        rad = 32'h7FFFFFFF;
      end
      set_box(l, t, r, b, rad, (ph == 9) ? 32'h7FFFFFFF : $urandom_range(32'h50000));
      idle_pct = (ph == 5) ? 0 : 38;
      if (ph == 6) begin
        fork
          begin
            hold_off = 1;
            repeat (200) @(negedge clk);
            hold_off = 0;
          end
        join_none
      end
      for (int i = 0; i < 125; i++) begin
        if ($urandom_range(9) == 0)
          send_circle($urandom, $urandom, $urandom, $urandom);
        else
          send_circle(near($urandom_range(1) ? l : r, 2 * rad + 16),
                      near($urandom_range(1) ? b : t, 2 * rad + 16),
                      $urandom, $urandom);
      end
    end
    in_valid <= 0;
    idle_pct = 38;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/cbcr_pkg.sv
hw/rtl/cbcr_sqrt.sv
hw/rtl/cbcr_div.sv
hw/rtl/circle_box_collision_response_unit.sv
test/cbcr_checker.sv
test/tb_circle_box_collision_response_unit.sv
